FILE: sv/rmir_pkg.sv
// rmir_pkg: shared types, codes and sizes for the running median block
// used by rmir_cell, rmir_ctrl and running_median_insert_remove
`default_nettype none

package rmir_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int DATA_W       = 32;
    localparam int KIND_W       = 2;
    localparam int STATUS_W     = 3;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_MEDIAN   = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_CLEARED  = 3'd4;

    typedef enum logic [0:0] {
        STATE_IDLE,
        STATE_DRAIN
    } state_t;

    typedef struct packed {
        logic                     insert;
        logic                     remove;
        logic                     tap_shift;
        logic signed [DATA_W-1:0] value;
    } cell_ctl_t;

endpackage

`default_nettype wire

FILE: sv/rmir_cell.sv
// rmir_cell: one slot of the sorted chain plus one stage of the tap line
// depends on rmir_pkg
`default_nettype none

module rmir_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 9,
    parameter int IDX_W = 8
) (
    input  wire                               clk,
    input  rmir_pkg::cell_ctl_t               ctl,
    input  wire  [CNT_W-1:0]                  count,
    input  wire  [IDX_W-1:0]                  mid,
    input  wire                               lo_gt,
    input  wire  signed [rmir_pkg::DATA_W-1:0] lo_val,
    input  wire  signed [rmir_pkg::DATA_W-1:0] hi_val,
    input  wire  signed [rmir_pkg::DATA_W-1:0] hi_tap,
    output logic                              gt,
    output logic signed [rmir_pkg::DATA_W-1:0] val,
    output logic signed [rmir_pkg::DATA_W-1:0] tap
);

    logic signed [rmir_pkg::DATA_W-1:0] val_reg;
    logic signed [rmir_pkg::DATA_W-1:0] val_next;
    logic signed [rmir_pkg::DATA_W-1:0] tap_reg;
    logic signed [rmir_pkg::DATA_W-1:0] tap_next;
    logic                              occupied;
    logic                              at_count;
    logic                              at_mid;
    logic                              above_mid;

    assign occupied  = CNT_W'(INDEX) < count;
    assign at_count  = CNT_W'(INDEX) == count;
    assign at_mid    = IDX_W'(INDEX) == mid;
    assign above_mid = IDX_W'(INDEX) >= mid;
    assign gt        = occupied && (val_reg > ctl.value);

    always_comb
    begin
        val_next = val_reg;
        if (ctl.insert)
        begin
            if (lo_gt)
            begin
                val_next = lo_val;
            end
            else if (gt || at_count)
            begin
                val_next = ctl.value;
            end
        end
        else if (ctl.remove && above_mid)
        begin
            val_next = hi_val;
        end
    end

    always_comb
    begin
        tap_next = tap_reg;
        if (ctl.remove && at_mid)
        begin
            tap_next = val_reg;
        end
        else if (ctl.tap_shift)
        begin
            tap_next = hi_tap;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        tap_reg <= tap_next;
    end

    assign val = val_reg;
    assign tap = tap_reg;

endmodule

`default_nettype wire

FILE: sv/rmir_ctrl.sv
// rmir_ctrl: handshake, entry count, drain sequencer and result register
// depends on rmir_pkg
`default_nettype none

module rmir_ctrl #(
    parameter int CAPACITY = rmir_pkg::CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1),
    parameter int IDX_W    = $clog2(CAPACITY)
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire  [rmir_pkg::KIND_W-1:0]         kind,
    input  wire  signed [rmir_pkg::DATA_W-1:0]  value,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic [rmir_pkg::STATUS_W-1:0]       status,
    output logic signed [rmir_pkg::DATA_W-1:0]  median,
    input  wire  signed [rmir_pkg::DATA_W-1:0]  tap0,
    output rmir_pkg::cell_ctl_t                 ctl,
    output logic [CNT_W-1:0]                    count,
    output logic [IDX_W-1:0]                    mid
);

    rmir_pkg::state_t                  state_reg;
    rmir_pkg::state_t                  state_next;
    logic [CNT_W-1:0]                  count_reg;
    logic [CNT_W-1:0]                  count_next;
    logic [IDX_W-1:0]                  drain_reg;
    logic [IDX_W-1:0]                  drain_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [rmir_pkg::STATUS_W-1:0]     status_reg;
    logic [rmir_pkg::STATUS_W-1:0]     status_next;
    logic signed [rmir_pkg::DATA_W-1:0] median_reg;
    logic signed [rmir_pkg::DATA_W-1:0] median_next;

    logic                              out_free;
    logic                              accept;
    logic                              full;
    logic                              empty;
    logic                              do_ins;
    logic                              do_rem;
    logic                              drain_done;
    logic [CNT_W-1:0]                  count_m1;
    logic [rmir_pkg::STATUS_W-1:0]     in_status;

    assign out_free   = !out_valid_reg || out_ready;
    assign accept     = in_valid && in_ready;
    assign full       = count_reg == CNT_W'(CAPACITY);
    assign empty      = count_reg == '0;
    assign count_m1   = count_reg - CNT_W'(1);
    assign mid        = IDX_W'(count_m1 >> 1);
    assign drain_done = (state_reg == rmir_pkg::STATE_DRAIN) && (drain_reg == '0) && out_free;

    always_comb
    begin
        do_ins    = 1'b0;
        do_rem    = 1'b0;
        in_status = rmir_pkg::STATUS_CLEARED;
        case (kind)
            rmir_pkg::KIND_INSERT:
            begin
                do_ins    = accept && !full;
                in_status = full ? rmir_pkg::STATUS_FULL : rmir_pkg::STATUS_INSERTED;
            end
            rmir_pkg::KIND_REMOVE:
            begin
                do_rem    = accept && !empty;
                in_status = empty ? rmir_pkg::STATUS_EMPTY : rmir_pkg::STATUS_MEDIAN;
            end
            default:
            begin
                in_status = rmir_pkg::STATUS_CLEARED;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rmir_pkg::STATE_IDLE:
            begin
                if (do_rem)
                begin
                    state_next = rmir_pkg::STATE_DRAIN;
                end
            end
            rmir_pkg::STATE_DRAIN:
            begin
                if (drain_done)
                begin
                    state_next = rmir_pkg::STATE_IDLE;
                end
            end
            default:
            begin
                state_next = rmir_pkg::STATE_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready      = 1'b0;
        ctl.tap_shift = do_rem;
        case (state_reg)
            rmir_pkg::STATE_IDLE:
            begin
                in_ready = out_free;
            end
            rmir_pkg::STATE_DRAIN:
            begin
                ctl.tap_shift = drain_reg != '0;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        ctl.insert = do_ins;
        ctl.remove = do_rem;
        ctl.value  = value;
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rem)
        begin
            count_next = count_m1;
        end
        else if (accept && (kind != rmir_pkg::KIND_INSERT) && (kind != rmir_pkg::KIND_REMOVE))
        begin
            count_next = '0;
        end
    end

    always_comb
    begin
        drain_next = drain_reg;
        if (do_rem)
        begin
            drain_next = mid;
        end
        else if ((state_reg == rmir_pkg::STATE_DRAIN) && (drain_reg != '0))
        begin
            drain_next = drain_reg - IDX_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        median_next    = median_reg;
        if (accept && !do_rem)
        begin
            out_valid_next = 1'b1;
            status_next    = in_status;
            median_next    = '0;
        end
        else if (drain_done)
        begin
            out_valid_next = 1'b1;
            status_next    = rmir_pkg::STATUS_MEDIAN;
            median_next    = tap0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rmir_pkg::STATE_IDLE;
            count_reg     <= '0;
            drain_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            drain_reg     <= drain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        median_reg <= median_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign median    = median_reg;
    assign count     = count_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rmir_pkg::STATE_DRAIN) |-> !in_ready)
        else $error("input taken while draining");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        do_ins |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the store");

    a_drain_result: assert property (@(posedge clk) disable iff (!rst_n)
        drain_done |=> out_valid_reg && (status_reg == rmir_pkg::STATUS_MEDIAN)
            && (state_reg == rmir_pkg::STATE_IDLE))
        else $error("drain ended without a median result");

    a_remove_drains: assert property (@(posedge clk) disable iff (!rst_n)
        do_rem |=> (state_reg == rmir_pkg::STATE_DRAIN) && (drain_reg == $past(mid)))
        else $error("remove did not start the drain");
`endif

endmodule

`default_nettype wire

FILE: sv/running_median_insert_remove.sv
// running_median_insert_remove: sorted chain of cells serving a running lower median
// depends on rmir_pkg, rmir_cell, rmir_ctrl
//
//   channel | signals                     | direction
//   --------+-----------------------------+----------
//   input   | in_valid in_ready kind value | in
//   result  | out_valid out_ready status median | out
//
// insert and clear: one result each, taken while idle with the output register free
// remove: the taken value walks the tap line one cell per cycle to cell 0
// no clearing pass after reset; only the entry count and control state reset
// a stalled result holds in the output register; a new transaction is taken when it frees
`default_nettype none

module running_median_insert_remove #(
    parameter int CAPACITY = rmir_pkg::CAPACITY_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire  [rmir_pkg::KIND_W-1:0]         kind,
    input  wire  signed [rmir_pkg::DATA_W-1:0]  value,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic [rmir_pkg::STATUS_W-1:0]       status,
    output logic signed [rmir_pkg::DATA_W-1:0]  median
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    rmir_pkg::cell_ctl_t                ctl;
    logic [CNT_W-1:0]                   count;
    logic [IDX_W-1:0]                   mid;
    logic                               gt_w  [CAPACITY];
    logic signed [rmir_pkg::DATA_W-1:0] val_w [CAPACITY];
    logic signed [rmir_pkg::DATA_W-1:0] tap_w [CAPACITY];

    rmir_ctrl #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W),
        .IDX_W    (IDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .median    (median),
        .tap0      (tap_w[0]),
        .ctl       (ctl),
        .count     (count),
        .mid       (mid)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                               lo_gt;
        logic signed [rmir_pkg::DATA_W-1:0] lo_val;
        logic signed [rmir_pkg::DATA_W-1:0] hi_val;
        logic signed [rmir_pkg::DATA_W-1:0] hi_tap;

        if (i == 0)
        begin : g_bottom
            assign lo_gt  = 1'b0;
            assign lo_val = '0;
        end
        else
        begin : g_lower
            assign lo_gt  = gt_w[i-1];
            assign lo_val = val_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_top
            assign hi_val = '0;
            assign hi_tap = '0;
        end
        else
        begin : g_upper
            assign hi_val = val_w[i+1];
            assign hi_tap = tap_w[i+1];
        end

        rmir_cell #(
            .INDEX (i),
            .CNT_W (CNT_W),
            .IDX_W (IDX_W)
        ) u_cell (
            .clk    (clk),
            .ctl    (ctl),
            .count  (count),
            .mid    (mid),
            .lo_gt  (lo_gt),
            .lo_val (lo_val),
            .hi_val (hi_val),
            .hi_tap (hi_tap),
            .gt     (gt_w[i]),
            .val    (val_w[i]),
            .tap    (tap_w[i])
        );
    end

endmodule

`default_nettype wire

FILE: dv/running_median_checker.sv
// running_median_checker: watches both channels of the running median block, keeps its own
// ordered store, predicts each result and compares status and median field by field
// depends on rmir_pkg
`timescale 1ns / 1ps

module running_median_checker #(
    parameter int CAPACITY = rmir_pkg::CAPACITY_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    input  wire                                 in_ready,
    input  wire  [rmir_pkg::KIND_W-1:0]         kind,
    input  wire  signed [rmir_pkg::DATA_W-1:0]  value,
    input  wire                                 out_valid,
    input  wire                                 out_ready,
    input  wire  [rmir_pkg::STATUS_W-1:0]       status,
    input  wire  signed [rmir_pkg::DATA_W-1:0]  median,
    output int                                  errors,
    output int                                  pending
);

    typedef struct packed {
        logic [rmir_pkg::STATUS_W-1:0]      status;
        logic signed [rmir_pkg::DATA_W-1:0] median;
    } outcome_t;

    outcome_t                           outcome_q[$];
    logic signed [rmir_pkg::DATA_W-1:0] ordered[CAPACITY];
    int                                 fill;
    int                                 err_count;

    function automatic outcome_t apply_item(input logic [rmir_pkg::KIND_W-1:0] k,
                                            input logic signed [rmir_pkg::DATA_W-1:0] v);
        outcome_t r;
        int       pos;
        int       idx;
        r.median = '0;
        if (k == rmir_pkg::KIND_INSERT)
        begin
            if (fill >= CAPACITY)
            begin
                r.status = rmir_pkg::STATUS_FULL;
            end
            else
            begin
                pos = fill;
                while (pos > 0 && ordered[pos-1] > v)
                begin
                    ordered[pos] = ordered[pos-1];
                    pos--;
                end
                ordered[pos] = v;
                fill++;
                r.status = rmir_pkg::STATUS_INSERTED;
            end
        end
        else if (k == rmir_pkg::KIND_REMOVE)
        begin
            if (fill == 0)
            begin
                r.status = rmir_pkg::STATUS_EMPTY;
            end
            else
            begin
                idx = (fill - 1) / 2;
                r.median = ordered[idx];
                for (int i = idx; i + 1 < fill; i++)
                begin
                    ordered[i] = ordered[i+1];
                end
                fill--;
                r.status = rmir_pkg::STATUS_MEDIAN;
            end
        end
        else
        begin
            // clear and the spare code both empty the store
            fill = 0;
            r.status = rmir_pkg::STATUS_CLEARED;
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        outcome_t oldest;
        if (!rst_n)
        begin
            fill = 0;
            err_count = 0;
            outcome_q.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (outcome_q.size() == 0)
                begin
                    $display("%0t: unexpected result status %0d median %0d",
                             $time, status, median);
                    err_count++;
                end
                else
                begin
                    oldest = outcome_q.pop_front();
                    if (status !== oldest.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, oldest.status, status);
                        err_count++;
                    end
                    if (median !== oldest.median)
                    begin
                        $display("%0t: median expected %0d actual %0d",
                                 $time, oldest.median, median);
                        err_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                outcome_q.push_back(apply_item(kind, value));
            end
        end
        errors  <= err_count;
        pending <= outcome_q.size();
    end

endmodule

FILE: dv/testbench.sv
// testbench: drives the running median block with directed and random transactions under
// several idle and stall mixes; the verdict uses the checker's error and pending counts
// depends on rmir_pkg, running_median_insert_remove, running_median_checker
`timescale 1ns / 1ps

module testbench;

    localparam int CAP        = rmir_pkg::CAPACITY_DEF;
    localparam int LIMIT      = 2000000;
    localparam int HOLD       = 300;
    localparam int SETTLE     = CAP / 2 + 8;
    localparam int RAND_ITEMS = 450;

    localparam logic [rmir_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;

    logic                               clk;
    logic                               rst_n;
    logic                               in_valid;
    logic [rmir_pkg::KIND_W-1:0]        kind;
    logic signed [rmir_pkg::DATA_W-1:0] value;
    logic                               out_ready;
    wire                                in_ready;
    wire                                out_valid;
    wire  [rmir_pkg::STATUS_W-1:0]      status;
    wire  signed [rmir_pkg::DATA_W-1:0] median;
    int                                 errors;
    int                                 pending;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_seq       = 0;
    int cycles         = 0;
    int sent           = 0;
    int level          = 0;

    running_median_insert_remove #(
        .CAPACITY(CAP)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .value    (value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status   (status),
        .median   (median)
    );

    running_median_checker #(
        .CAPACITY(CAP)
    ) u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .value    (value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status   (status),
        .median   (median),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off on each bump of hold_seq
    initial
    begin
        int seen;
        seen = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seq != seen)
            begin
                seen = hold_seq;
                out_ready <= 1'b0;
                repeat (HOLD) @(posedge clk);
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic logic signed [rmir_pkg::DATA_W-1:0] pick_value();
        int c;
        c = $urandom_range(99);
        if (c < 10)
        begin
            case ($urandom_range(5))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7fff_ffff;
                2:       return 32'sh0000_0000;
                3:       return -32'sd1;
                4:       return 32'sh8000_0001;
                default: return 32'sh7fff_fffe;
            endcase
        end
        else if (c < 40)
        begin
            return $signed($urandom_range(16)) - 8;
        end
        return $signed($urandom());
    endfunction

    task automatic send_item(input logic [rmir_pkg::KIND_W-1:0] k,
                             input logic signed [rmir_pkg::DATA_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        value    <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent++;
        if (k == rmir_pkg::KIND_INSERT)
        begin
            if (level < CAP)
            begin
                level++;
            end
        end
        else if (k == rmir_pkg::KIND_REMOVE)
        begin
            if (level > 0)
            begin
                level--;
            end
        end
        else
        begin
            level = 0;
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic run_phase(input int idle, input int stall, input int items,
                             input bit with_fill, input bit with_hold);
        int target;
        int r;
        int c;
        int n;
        int peak;
        send_idle_pct  <= idle;
        recv_stall_pct <= stall;
        target = sent + items;
        if (with_hold)
        begin
            hold_seq <= hold_seq + 1;
        end
        if (with_fill)
        begin
            // fill to capacity, bounce off the full store, then drain part way and clear
            while (level < CAP) send_item(rmir_pkg::KIND_INSERT, pick_value());
            repeat (3) send_item(rmir_pkg::KIND_INSERT, pick_value());
            repeat (4) send_item(rmir_pkg::KIND_REMOVE, pick_value());
            repeat (5) send_item(rmir_pkg::KIND_INSERT, pick_value());
            n = $urandom_range(20, 60);
            repeat (n) send_item(rmir_pkg::KIND_REMOVE, $signed($urandom()));
            send_item(rmir_pkg::KIND_CLEAR, $signed($urandom()));
        end
        while (sent < target)
        begin
            r = $urandom_range(99);
            if (r < 60)
            begin
                n = $urandom_range(10, 40);
                repeat (n)
                begin
                    c = $urandom_range(99);
                    if (c < ((level < 32) ? 55 : 40))
                    begin
                        send_item(rmir_pkg::KIND_INSERT, pick_value());
                    end
                    else if (c < 95)
                    begin
                        send_item(rmir_pkg::KIND_REMOVE, $signed($urandom()));
                    end
                    else if (c < 98)
                    begin
                        send_item(rmir_pkg::KIND_CLEAR, $signed($urandom()));
                    end
                    else
                    begin
                        send_item(KIND_SPARE, $signed($urandom()));
                    end
                end
            end
            else if (r < 85)
            begin
                peak = $urandom_range(8, 100);
                while (level < peak) send_item(rmir_pkg::KIND_INSERT, pick_value());
                while (level > 0) send_item(rmir_pkg::KIND_REMOVE, pick_value());
                n = $urandom_range(1, 2);
                repeat (n) send_item(rmir_pkg::KIND_REMOVE, pick_value());
            end
            else
            begin
                n = $urandom_range(4, 16);
                repeat (n) send_item(rmir_pkg::KIND_W'($urandom_range(3)), $signed($urandom()));
            end
        end
        wait_drained();
    endtask

    initial
    begin
        in_valid = 1'b0;
        kind     = rmir_pkg::KIND_INSERT;
        value    = '0;
        rst_n    = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty remove, extremes, duplicates, spare code, ignored value
        send_item(rmir_pkg::KIND_REMOVE, 32'sh7fff_ffff);
        send_item(rmir_pkg::KIND_CLEAR, 32'sh0000_0000);
        send_item(rmir_pkg::KIND_INSERT, 32'sh7fff_ffff);
        send_item(rmir_pkg::KIND_INSERT, 32'sh8000_0000);
        send_item(rmir_pkg::KIND_INSERT, 32'sh0000_0000);
        send_item(rmir_pkg::KIND_INSERT, -32'sd1);
        send_item(rmir_pkg::KIND_INSERT, -32'sd1);
        send_item(rmir_pkg::KIND_INSERT, 32'sd1);
        send_item(rmir_pkg::KIND_REMOVE, -32'sd1);
        send_item(rmir_pkg::KIND_REMOVE, 32'sh5555_5555);
        send_item(rmir_pkg::KIND_REMOVE, 32'sh0000_0000);
        send_item(KIND_SPARE, 32'shffff_ffff);
        send_item(rmir_pkg::KIND_REMOVE, 32'shffff_ffff);
        send_item(rmir_pkg::KIND_INSERT, 32'sh5555_5555);
        send_item(rmir_pkg::KIND_INSERT, 32'shaaaa_aaaa);
        send_item(rmir_pkg::KIND_INSERT, 32'sd5);
        send_item(rmir_pkg::KIND_INSERT, 32'sd5);
        send_item(rmir_pkg::KIND_REMOVE, 32'sh0000_0000);
        send_item(rmir_pkg::KIND_REMOVE, 32'sh0000_0000);
        send_item(rmir_pkg::KIND_REMOVE, 32'sh0000_0000);
        send_item(rmir_pkg::KIND_REMOVE, 32'sh0000_0000);
        send_item(rmir_pkg::KIND_REMOVE, 32'sh0000_0000);
        send_item(rmir_pkg::KIND_INSERT, 32'sh8000_0000);
        send_item(rmir_pkg::KIND_CLEAR, 32'shffff_ffff);
        wait_drained();

        run_phase(0, 0, RAND_ITEMS, 1'b1, 1'b1);
        run_phase(88, 0, RAND_ITEMS, 1'b0, 1'b0);
        run_phase(0, 88, RAND_ITEMS, 1'b1, 1'b0);
        run_phase(33, 33, RAND_ITEMS, 1'b0, 1'b1);

        repeat (SETTLE) @(posedge clk);
        if (errors == 0 && pending == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/rmir_pkg.sv
sv/rmir_cell.sv
sv/rmir_ctrl.sv
sv/running_median_insert_remove.sv
dv/running_median_checker.sv
dv/testbench.sv
